[sv/stb_pkg.sv]
// Shared types and constants for the splat tile bounds block.
// No dependencies; every other file imports this package.
package stb_pkg;

  localparam int unsigned PIX_W      = 13;   // screen size and pixel coordinate width
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned IDX_W      = 20;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned TILE_W     = 8;
  localparam int unsigned NUM_W      = 22;   // cx + 4096 +/- 3*(|a|+|b|)
  localparam int unsigned PROD_W     = NUM_W + PIX_W + 1;
  localparam int unsigned NDC_HALF   = 4096; // 0.5 in NDC terms of Q2.13
  localparam int unsigned PIX_SH     = 13;   // divide by 8192
  localparam int unsigned TILE_MAX   = 255;

  localparam int unsigned TILE_PIXELS_DEF    = 16;
  localparam int unsigned MAX_SCREEN_DIM_DEF = 4096;
  localparam logic [PIX_W-1:0] WIDTH_RST  = 13'd1920;
  localparam logic [PIX_W-1:0] HEIGHT_RST = 13'd1080;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 4'd0,
    REG_SCREEN_HEIGHT = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic        [IDX_W-1:0]   splat_index;
    logic signed [COORD_W-1:0] ctr_x;
    logic signed [COORD_W-1:0] ctr_y;
    logic signed [COORD_W-1:0] axis_a_x;
    logic signed [COORD_W-1:0] axis_a_y;
    logic signed [COORD_W-1:0] axis_b_x;
    logic signed [COORD_W-1:0] axis_b_y;
  } splat_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  out_splat_index;
    logic              is_empty;
    logic [TILE_W-1:0] tile_left;
    logic [TILE_W-1:0] tile_right;
    logic [TILE_W-1:0] tile_top;
    logic [TILE_W-1:0] tile_bottom;
  } splat_out_t;

endpackage

[sv/stb_if.sv]
// Channel interfaces for the splat tile bounds block: a valid/ready item
// stream with a payload type parameter, and the configuration write port.
// Depends on stb_pkg.
interface stb_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stb_cfg_if
  import stb_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PIX_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/splat_tile_bounds_top.sv]
// Splat tile bounds: tile rectangle covered by the 3-sigma extent of a splat.
// Depends on stb_pkg and the interfaces in stb_if.sv.
//
// Usage:
//   splat_in  (sink)   one projected splat per item: index, NDC center, two axes.
//   tile_out  (source) one result item per splat: index, empty flag, inclusive
//                      tile column and row range.
//   cfg       (sink)   register writes, always ready; index 0 is the screen
//                      width, index 1 the height, other indexes are dropped.
//                      Write only while no items are in flight.
// Timing: three register stages (extent numerators, clamped pixel bounds,
// result register); an accepted item passes through them in that order.
// Throughput is one item per cycle while tile_out.ready is high; each stage
// holds its own item and only stalls where the next stage is full and not moving.
// When the receiver holds ready low the result register keeps its item and
// the stages behind it fill up; splat_in.ready drops once all three are full.
// Reset (rst, synchronous) empties the pipeline and loads 1920 x 1080.
module splat_tile_bounds_top
  import stb_pkg::*;
#(
  parameter int unsigned TILE_PIXELS    = TILE_PIXELS_DEF,
  parameter int unsigned MAX_SCREEN_DIM = MAX_SCREEN_DIM_DEF
) (
  input  logic    clk,
  input  logic    rst,
  stb_stream_if.sink   splat_in,
  stb_stream_if.source tile_out,
  stb_cfg_if.sink      cfg
);

  // Tile index by reciprocal multiply, exact for any pixel below 2**PIX_W.
  localparam int unsigned TILE_SH  = $clog2(TILE_PIXELS);
  localparam int unsigned RECIP_SH = PIX_W + TILE_SH;
  localparam int unsigned RECIP_W  = RECIP_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'(1) << RECIP_SH) + 64'(TILE_PIXELS) - 64'(1)) / RECIP_W'(TILE_PIXELS);
  localparam int unsigned QUOT_W   = PIX_W + RECIP_W - RECIP_SH;

  logic [PIX_W-1:0] screen_width;
  logic [PIX_W-1:0] screen_height;

  // stage 1: numerators of the four pixel edges
  logic                    v1;
  logic [IDX_W-1:0]        idx1;
  logic signed [NUM_W-1:0] lo_x1, hi_x1, lo_y1, hi_y1;
  // stage 2: clamped pixel bounds
  logic                    v2;
  logic [IDX_W-1:0]        idx2;
  logic                    empty2;
  logic [PIX_W-1:0]        px_lo2, px_hi2, py_lo2, py_hi2;
  // stage 3: result register
  logic                    v3;
  splat_out_t              res3;

  logic adv1, adv2, adv3;

  assign adv3 = !v3 || tile_out.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;

  assign splat_in.ready = adv1;
  assign tile_out.valid = v3;
  assign tile_out.data  = res3;
  assign cfg.ready      = 1'b1;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RST;
      screen_height <= HEIGHT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg.data;
        REG_SCREEN_HEIGHT: screen_height <= cfg.data;
        default: ;
      endcase
    end
  end

  function automatic logic [PIX_W-1:0] eff_size(input logic [PIX_W-1:0] s);
    logic [PIX_W-1:0] r;
    r = s;
    if (s == '0) r = PIX_W'(1);
    else if (32'(s) > MAX_SCREEN_DIM) r = PIX_W'(MAX_SCREEN_DIM);
    return r;
  endfunction

  function automatic logic [COORD_W:0] abs_c(input logic signed [COORD_W-1:0] a);
    logic signed [COORD_W:0] e;
    e = (COORD_W+1)'(a);
    return e[COORD_W] ? (COORD_W+1)'(-e) : (COORD_W+1)'(e);
  endfunction

  // ---------------------------------------------------------------- stage 1
  logic [COORD_W+1:0]      ext_sum_x, ext_sum_y;
  logic signed [NUM_W-1:0] sx, sy, cx, cy, half;

  always_comb begin
    ext_sum_x = (COORD_W+2)'(abs_c(splat_in.data.axis_a_x))
              + (COORD_W+2)'(abs_c(splat_in.data.axis_b_x));
    ext_sum_y = (COORD_W+2)'(abs_c(splat_in.data.axis_a_y))
              + (COORD_W+2)'(abs_c(splat_in.data.axis_b_y));
    sx   = NUM_W'(ext_sum_x) + (NUM_W'(ext_sum_x) <<< 1);
    sy   = NUM_W'(ext_sum_y) + (NUM_W'(ext_sum_y) <<< 1);
    cx   = NUM_W'(splat_in.data.ctr_x);
    cy   = NUM_W'(splat_in.data.ctr_y);
    half = NUM_W'(NDC_HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= splat_in.valid;
    end
    if (adv1 && splat_in.valid) begin
      idx1  <= splat_in.data.splat_index;
      lo_x1 <= cx + half - sx;
      hi_x1 <= cx + half + sx;
      lo_y1 <= half - cy - sy;
      hi_y1 <= half - cy + sy;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [PIX_W-1:0]         w_eff, h_eff;
  logic signed [PROD_W-1:0] w_s, h_s, w_max, h_max;
  logic signed [PROD_W-1:0] p_lo_x, p_hi_x, p_lo_y, p_hi_y;
  logic signed [PROD_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic                     empty_next;

  always_comb begin
    w_eff  = eff_size(screen_width);
    h_eff  = eff_size(screen_height);
    w_s    = PROD_W'({1'b0, w_eff});
    h_s    = PROD_W'({1'b0, h_eff});
    w_max  = w_s - PROD_W'(1);
    h_max  = h_s - PROD_W'(1);
    p_lo_x = PROD_W'(lo_x1) * w_s;
    p_hi_x = PROD_W'(hi_x1) * w_s;
    p_lo_y = PROD_W'(lo_y1) * h_s;
    p_hi_y = PROD_W'(hi_y1) * h_s;
    // floor on the low edge, ceil on the high edge
    lo_x = p_lo_x >>> PIX_SH;
    lo_y = p_lo_y >>> PIX_SH;
    hi_x = (p_hi_x + PROD_W'((1 << PIX_SH) - 1)) >>> PIX_SH;
    hi_y = (p_hi_y + PROD_W'((1 << PIX_SH) - 1)) >>> PIX_SH;
    if (lo_x < 0) lo_x = '0;
    if (lo_y < 0) lo_y = '0;
    if (hi_x > w_max) hi_x = w_max;
    if (hi_y > h_max) hi_y = h_max;
    empty_next = (lo_x > hi_x) || (lo_y > hi_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2 && v1) begin
      idx2   <= idx1;
      empty2 <= empty_next;
      // bounds are meaningful only when the rectangle is not empty
      px_lo2 <= PIX_W'(lo_x);
      px_hi2 <= PIX_W'(hi_x);
      py_lo2 <= PIX_W'(lo_y);
      py_hi2 <= PIX_W'(hi_y);
    end
  end

  // ---------------------------------------------------------------- stage 3
  function automatic logic [TILE_W-1:0] to_tile(input logic [PIX_W-1:0] p);
    logic [PIX_W+RECIP_W-1:0] prod;
    logic [QUOT_W-1:0]        q;
    prod = (PIX_W+RECIP_W)'(p) * (PIX_W+RECIP_W)'(RECIP);
    q    = QUOT_W'(prod >> RECIP_SH);
    return (32'(q) > TILE_MAX) ? TILE_W'(TILE_MAX) : TILE_W'(q);
  endfunction

  splat_out_t res_next;

  always_comb begin
    res_next.out_splat_index = idx2;
    res_next.is_empty        = empty2;
    res_next.tile_left       = '0;
    res_next.tile_right      = '0;
    res_next.tile_top        = '0;
    res_next.tile_bottom     = '0;
    if (!empty2) begin
      res_next.tile_left   = to_tile(px_lo2);
      res_next.tile_right  = to_tile(px_hi2);
      res_next.tile_top    = to_tile(py_lo2);
      res_next.tile_bottom = to_tile(py_hi2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
    if (adv3 && v2) begin
      res3 <= res_next;
    end
  end

endmodule

[sv/stb_checker.sv]
// Port-level checks for splat_tile_bounds_top, attached by bind.
// Depends on stb_pkg.
module stb_checker
  import stb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input splat_out_t out_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result item changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_empty |->
      out_data.tile_left == '0 && out_data.tile_right == '0 &&
      out_data.tile_top == '0 && out_data.tile_bottom == '0)
    else $error("empty result carries tiles");

  a_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_empty |->
      out_data.tile_left <= out_data.tile_right &&
      out_data.tile_top <= out_data.tile_bottom)
    else $error("tile range reversed");

  a_rst_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered right after reset");

endmodule

bind splat_tile_bounds_top stb_checker u_stb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (tile_out.valid),
  .out_ready (tile_out.ready),
  .out_data  (tile_out.data)
);
